@@ hw/rtl/rangefinder_frame_parser_core_assert.svh @@
// assertion macros for the rangefinder frame parser
// no dependencies; included by modules that carry concurrent checks
`ifndef RANGEFINDER_FRAME_PARSER_CORE_ASSERT_SVH
`define RANGEFINDER_FRAME_PARSER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RFFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RFFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rffp_pkg.sv @@
// shared types and constants for the rangefinder frame parser
// no dependencies
package rffp_pkg;

    localparam int PAYLOAD_LEN = 10;
    localparam int TYPE_POS    = 0;
    localparam int DIST_POS    = 5;

    localparam int CNT_W = $clog2(PAYLOAD_LEN);

    localparam logic [15:0] FUNC_TARGET = 16'h03ff;
    localparam logic [7:0]  CRC_WILD    = 8'hff;

    // register indexes of the configuration port
    localparam logic [2:0] REG_SYNC_ONE  = 3'd0;
    localparam logic [2:0] REG_SYNC_TWO  = 3'd1;
    localparam logic [2:0] REG_END_BYTE  = 3'd2;
    localparam logic [2:0] REG_TYPE_CODE = 3'd3;
    localparam logic [2:0] REG_CRC_POLY  = 3'd4;
    localparam logic [2:0] REG_CRC_REFL  = 3'd5;

    typedef enum logic [3:0] {
        PH_SYNC1  = 4'd0,
        PH_SYNC2  = 4'd1,
        PH_ADDR   = 4'd2,
        PH_ERR    = 4'd3,
        PH_FC_LO  = 4'd4,
        PH_FC_HI  = 4'd5,
        PH_LEN_LO = 4'd6,
        PH_LEN_HI = 4'd7,
        PH_DATA   = 4'd8,
        PH_CRC    = 4'd9,
        PH_END1   = 4'd10,
        PH_END2   = 4'd11
    } t_phase;

    // datapath strobes driven by the phase decoder
    typedef struct packed {
        logic crc_clear;
        logic crc_update;
        logic cap_addr;
        logic cap_err;
        logic cap_fc_lo;
        logic cap_fc_hi;
        logic cap_len_lo;
        logic cap_data;
        logic cnt_clear;
        logic cnt_inc;
        logic result;
    } t_ctrl;

endpackage

@@ hw/rtl/rangefinder_frame_parser_core.sv @@
// rangefinder frame parser: byte-serial frame tracker with running crc-8
// depends on rffp_pkg and rangefinder_frame_parser_core_assert.svh
//
// usage:
//   input channel   i_rx_valid / o_rx_stall / i_rx_byte: one received byte per
//                   request, taken at an edge with valid high and stall low
//   result channel  o_res_valid / i_res_stall / o_distance_hundredths /
//                   o_device_address: one request per good target frame
//   config channel  i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data;
//                   ready is always high, indexes above five are ignored
// throughput: one byte per cycle while o_rx_stall is low; every byte goes through the phase
//   decoder in the cycle it is taken, and address to payload bytes also through the crc-8 step
// result: a frame's result is registered into the output register, or into the skid
//   entry while the output register is full and stalled, as its second end byte is taken
// stall: the output register plus a one-entry skid buffer hold results while
//   the receiver stalls; bytes keep being taken until the skid entry fills,
//   then o_rx_stall is raised until the skid entry moves to the output register
// reset: synchronous, active low; parser returns to hunting for the first
//   sync byte, configuration takes its default values, result path empties
`include "rangefinder_frame_parser_core_assert.svh"

module rangefinder_frame_parser_core
    import rffp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,

    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [15:0] o_distance_hundredths,
    output logic [7:0]  o_device_address,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int TYPE_IDX = (TYPE_POS < PAYLOAD_LEN) ? TYPE_POS : 0;
    localparam int DLO_IDX  = (DIST_POS < PAYLOAD_LEN) ? DIST_POS : 0;
    localparam int DHI_IDX  = (DIST_POS + 1 < PAYLOAD_LEN) ? DIST_POS + 1 : 0;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_LEN - 1);

    // one crc-8 byte step, msb-first or reflected
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b,
                                            input logic [7:0] poly, input logic refl);
        logic [7:0] r;
        logic [7:0] rpoly;
        r = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            rpoly[7-i] = poly[i];
        end
        for (int i = 0; i < 8; i++) begin
            if (refl) begin
                r = r[0] ? ((r >> 1) ^ rpoly) : (r >> 1);
            end else begin
                r = r[7] ? ((r << 1) ^ poly) : (r << 1);
            end
        end
        return r;
    endfunction

    // configuration
    logic [7:0] r_sync_one, r_sync_two, r_end_byte, r_type_code, r_crc_poly;
    logic       r_crc_refl;

    // parser state
    t_phase            r_phase, n_phase;
    logic [CNT_W-1:0]  r_count;
    logic [7:0]        r_crc;
    logic [7:0]        r_addr;
    logic [7:0]        r_err;
    logic [15:0]       r_func;
    logic [7:0]        r_len_lo;
    logic [7:0]        r_payload [PAYLOAD_LEN];

    // result path
    logic        r_out_valid, r_skid_valid;
    logic [15:0] r_out_dist, r_skid_dist;
    logic [7:0]  r_out_addr, r_skid_addr;

    t_ctrl       ctrl;
    logic        rx_acc;
    logic        produce;
    logic        out_free;
    logic [7:0]  crc_next;
    logic [7:0]  type_byte, dist_lo, dist_hi;
    logic [15:0] res_dist;

    assign o_cfg_ready = 1'b1;
    assign o_rx_stall  = r_skid_valid;
    assign rx_acc      = i_rx_valid && !o_rx_stall;

    assign type_byte = (TYPE_POS < PAYLOAD_LEN) ? r_payload[TYPE_IDX] : 8'h00;
    assign dist_lo   = (DIST_POS < PAYLOAD_LEN) ? r_payload[DLO_IDX] : 8'h00;
    assign dist_hi   = (DIST_POS + 1 < PAYLOAD_LEN) ? r_payload[DHI_IDX] : 8'h00;
    assign res_dist  = {dist_hi, dist_lo};

    assign crc_next = crc_step(r_crc, i_rx_byte, r_crc_poly, r_crc_refl);

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_SYNC1:  n_phase = (i_rx_byte == r_sync_one) ? PH_SYNC2 : PH_SYNC1;
            PH_SYNC2:  n_phase = (i_rx_byte == r_sync_two) ? PH_ADDR : PH_SYNC1;
            PH_ADDR:   n_phase = PH_ERR;
            PH_ERR:    n_phase = PH_FC_LO;
            PH_FC_LO:  n_phase = PH_FC_HI;
            PH_FC_HI:  n_phase = PH_LEN_LO;
            PH_LEN_LO: n_phase = PH_LEN_HI;
            PH_LEN_HI: n_phase = ({i_rx_byte, r_len_lo} == 16'(PAYLOAD_LEN)) ?
                                 PH_DATA : PH_SYNC1;
            PH_DATA:   n_phase = (r_count == CNT_LAST) ? PH_CRC : PH_DATA;
            PH_CRC:    n_phase = (i_rx_byte == r_crc || i_rx_byte == CRC_WILD) ?
                                 PH_END1 : PH_SYNC1;
            PH_END1:   n_phase = (i_rx_byte == r_end_byte) ? PH_END2 : PH_SYNC1;
            PH_END2:   n_phase = PH_SYNC1;
            default:   n_phase = PH_SYNC1;
        endcase
    end

    // datapath strobes
    always_comb begin
        ctrl = '0;
        case (r_phase)
            PH_SYNC1: ;
            PH_SYNC2: begin
                if (i_rx_byte == r_sync_two) begin
                    ctrl.crc_clear = 1'b1;
                    ctrl.cnt_clear = 1'b1;
                end
            end
            PH_ADDR: begin
                ctrl.cap_addr   = 1'b1;
                ctrl.crc_update = 1'b1;
            end
            PH_ERR: begin
                ctrl.cap_err    = 1'b1;
                ctrl.crc_update = 1'b1;
            end
            PH_FC_LO: begin
                ctrl.cap_fc_lo  = 1'b1;
                ctrl.crc_update = 1'b1;
            end
            PH_FC_HI: begin
                ctrl.cap_fc_hi  = 1'b1;
                ctrl.crc_update = 1'b1;
            end
            PH_LEN_LO: begin
                ctrl.cap_len_lo = 1'b1;
                ctrl.crc_update = 1'b1;
            end
            PH_LEN_HI: begin
                if ({i_rx_byte, r_len_lo} == 16'(PAYLOAD_LEN)) begin
                    ctrl.crc_update = 1'b1;
                    ctrl.cnt_clear  = 1'b1;
                end
            end
            PH_DATA: begin
                ctrl.cap_data   = 1'b1;
                ctrl.crc_update = 1'b1;
                ctrl.cnt_inc    = (r_count != CNT_LAST);
            end
            PH_CRC: ;
            PH_END1: ;
            PH_END2: begin
                ctrl.cnt_clear = 1'b1;
                ctrl.result    = (i_rx_byte == r_end_byte) && (r_func == FUNC_TARGET) &&
                                 (r_err == 8'h00) && (type_byte == r_type_code);
            end
            default: ctrl.cnt_clear = 1'b1;
        endcase
    end

    assign produce = rx_acc && ctrl.result;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_one  <= 8'h55;
            r_sync_two  <= 8'h55;
            r_end_byte  <= 8'haa;
            r_type_code <= 8'h00;
            r_crc_poly  <= 8'h07;
            r_crc_refl  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SYNC_ONE:  r_sync_one  <= i_cfg_data;
                REG_SYNC_TWO:  r_sync_two  <= i_cfg_data;
                REG_END_BYTE:  r_end_byte  <= i_cfg_data;
                REG_TYPE_CODE: r_type_code <= i_cfg_data;
                REG_CRC_POLY:  r_crc_poly  <= i_cfg_data;
                REG_CRC_REFL:  r_crc_refl  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // parser control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_count <= '0;
            r_crc   <= 8'h00;
        end else if (rx_acc) begin
            r_phase <= n_phase;
            if (ctrl.cnt_clear) begin
                r_count <= '0;
            end else if (ctrl.cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (ctrl.crc_clear) begin
                r_crc <= 8'h00;
            end else if (ctrl.crc_update) begin
                r_crc <= crc_next;
            end
        end
    end

    // frame fields and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= 8'h00;
            r_err    <= 8'h00;
            r_func   <= 16'h0000;
            r_len_lo <= 8'h00;
        end else if (rx_acc) begin
            if (ctrl.cap_addr)   r_addr       <= i_rx_byte;
            if (ctrl.cap_err)    r_err        <= i_rx_byte;
            if (ctrl.cap_fc_lo)  r_func[7:0]  <= i_rx_byte;
            if (ctrl.cap_fc_hi)  r_func[15:8] <= i_rx_byte;
            if (ctrl.cap_len_lo) r_len_lo     <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_acc && ctrl.cap_data) begin
            r_payload[r_count] <= i_rx_byte;
        end
    end

    // output register with one skid entry
    assign out_free = !r_out_valid || !i_res_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid  <= r_skid_valid || produce;
                r_skid_valid <= r_skid_valid && produce;
            end else if (produce) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_dist  <= r_skid_dist;
                r_out_addr  <= r_skid_addr;
                r_skid_dist <= res_dist;
                r_skid_addr <= r_addr;
            end else begin
                r_out_dist <= res_dist;
                r_out_addr <= r_addr;
            end
        end else if (produce) begin
            r_skid_dist <= res_dist;
            r_skid_addr <= r_addr;
        end
    end

    assign o_res_valid           = r_out_valid;
    assign o_distance_hundredths = r_out_dist;
    assign o_device_address      = r_out_addr;

    `RFFP_ASSERT_NOW(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid entry held while output register empty")
    `RFFP_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, r_skid_valid && i_res_stall, r_skid_valid && r_out_valid, "buffered result lost under stall")
    `RFFP_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, produce, r_out_valid, "frame result did not reach output")
    `RFFP_ASSERT_NEXT(a_data_to_crc, i_clk, i_rst_n, rx_acc && r_phase == PH_DATA && r_count == CNT_LAST, r_phase == PH_CRC && r_count == CNT_LAST, "payload end not followed by crc phase")

endmodule

@@ test/tb_top.sv @@
// self-checking testbench for rangefinder_frame_parser_core: byte frames with random gaps,
// receiver stalls and a long hold-off, predicted results compared field by field
// depends on rffp_pkg and the rangefinder_frame_parser_core rtl
module tb_top;
    import rffp_pkg::*;

    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef enum {
        FR_GOOD, FR_CONTENT, FR_WILD_CRC, FR_BAD_CRC, FR_BAD_LEN,
        FR_BAD_SYNC2, FR_BAD_END1, FR_BAD_END2, FR_CUT
    } t_frame_kind;

    typedef struct packed {
        logic [15:0] hundredths;
        logic [7:0]  addr;
    } t_range;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_rx_valid = 1'b0;
    logic        o_rx_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_res_valid;
    logic        i_res_stall = 1'b0;
    logic [15:0] o_distance_hundredths;
    logic [7:0]  o_device_address;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = 3'd0;
    logic [7:0]  i_cfg_data = 8'h00;

    rangefinder_frame_parser_core uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_rx_valid            (i_rx_valid),
        .o_rx_stall            (o_rx_stall),
        .i_rx_byte             (i_rx_byte),
        .o_res_valid           (o_res_valid),
        .i_res_stall           (i_res_stall),
        .o_distance_hundredths (o_distance_hundredths),
        .o_device_address      (o_device_address),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [7:0] frame_bytes[$];
    t_range     expected_ranges[$];
    int         queued_bytes = 0;
    int         accepted_bytes = 0;
    int         mismatch_count = 0;
    bit         rx_took = 1'b0;
    bit         no_idle = 1'b0;
    int         hold_asked = 0;

    // predictor copy of configuration and parser state
    logic [7:0] cfg_sync_one, cfg_sync_two, cfg_end, cfg_type, cfg_poly;
    logic       cfg_refl;
    t_phase     prd_phase;
    int         prd_count;
    logic [7:0] prd_crc, prd_addr, prd_err, prd_len_lo;
    logic [15:0] prd_fc;
    logic [7:0] prd_payload [PAYLOAD_LEN];

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly, input logic refl);
        logic [7:0] r;
        logic [7:0] rpoly;
        r = crc ^ b;
        for (int i = 0; i < 8; i++) rpoly[7-i] = poly[i];
        for (int i = 0; i < 8; i++) begin
            if (refl) r = r[0] ? ((r >> 1) ^ rpoly) : (r >> 1);
            else r = r[7] ? ((r << 1) ^ poly) : (r << 1);
        end
        return r;
    endfunction

    function automatic logic [7:0] payload_byte(input int pos);
        return (pos < PAYLOAD_LEN) ? prd_payload[pos] : 8'h00;
    endfunction

    function automatic logic [7:0] byte_other_than(input logic [7:0] v);
        logic [7:0] r;
        do r = 8'($urandom_range(255)); while (r == v);
        return r;
    endfunction

    task automatic parse_rx_byte(input logic [7:0] b);
        case (prd_phase)
            PH_SYNC1: if (b == cfg_sync_one) prd_phase = PH_SYNC2;
            PH_SYNC2: begin
                if (b == cfg_sync_two) begin
                    prd_crc = 8'h00;
                    prd_count = 0;
                    prd_phase = PH_ADDR;
                end else begin
                    prd_phase = PH_SYNC1;
                end
            end
            PH_ADDR: begin
                prd_addr = b;
                prd_crc = crc8_next(prd_crc, b, cfg_poly, cfg_refl);
                prd_phase = PH_ERR;
            end
            PH_ERR: begin
                prd_err = b;
                prd_crc = crc8_next(prd_crc, b, cfg_poly, cfg_refl);
                prd_phase = PH_FC_LO;
            end
            PH_FC_LO: begin
                prd_fc[7:0] = b;
                prd_crc = crc8_next(prd_crc, b, cfg_poly, cfg_refl);
                prd_phase = PH_FC_HI;
            end
            PH_FC_HI: begin
                prd_fc[15:8] = b;
                prd_crc = crc8_next(prd_crc, b, cfg_poly, cfg_refl);
                prd_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                prd_len_lo = b;
                prd_crc = crc8_next(prd_crc, b, cfg_poly, cfg_refl);
                prd_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                if ({b, prd_len_lo} == 16'(PAYLOAD_LEN)) begin
                    prd_crc = crc8_next(prd_crc, b, cfg_poly, cfg_refl);
                    prd_count = 0;
                    prd_phase = PH_DATA;
                end else begin
                    prd_phase = PH_SYNC1;
                end
            end
            PH_DATA: begin
                if (prd_count < PAYLOAD_LEN) prd_payload[prd_count] = b;
                prd_crc = crc8_next(prd_crc, b, cfg_poly, cfg_refl);
                if (prd_count + 1 >= PAYLOAD_LEN) prd_phase = PH_CRC;
                else prd_count = prd_count + 1;
            end
            PH_CRC: prd_phase = (b == prd_crc || b == CRC_WILD) ? PH_END1 : PH_SYNC1;
            PH_END1: prd_phase = (b == cfg_end) ? PH_END2 : PH_SYNC1;
            PH_END2: begin
                if (b == cfg_end && prd_fc == FUNC_TARGET && prd_err == 8'h00 &&
                    payload_byte(TYPE_POS) == cfg_type)
                    expected_ranges.push_back('{hundredths: {payload_byte(DIST_POS + 1),
                                                             payload_byte(DIST_POS)},
                                                addr: prd_addr});
                prd_count = 0;
                prd_phase = PH_SYNC1;
            end
            default: begin
                prd_count = 0;
                prd_phase = PH_SYNC1;
            end
        endcase
    endtask

    // monitor: results, accepted bytes and register writes at the rising edge
    always @(posedge i_clk) begin : monitor
        t_range want;
        if (!i_rst_n) begin
            rx_took = 1'b0;
            cfg_sync_one = 8'h55;
            cfg_sync_two = 8'h55;
            cfg_end = 8'haa;
            cfg_type = 8'h00;
            cfg_poly = 8'h07;
            cfg_refl = 1'b0;
            prd_phase = PH_SYNC1;
            prd_count = 0;
            prd_crc = 8'h00;
            prd_addr = 8'h00;
            prd_err = 8'h00;
            prd_fc = 16'h0000;
            prd_len_lo = 8'h00;
            foreach (prd_payload[i]) prd_payload[i] = 8'h00;
        end else begin
            if (o_res_valid && !i_res_stall) begin
                if (expected_ranges.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got dist %h addr %h",
                             $time, o_distance_hundredths, o_device_address);
                    mismatch_count++;
                end else begin
                    want = expected_ranges.pop_front();
                    if (o_distance_hundredths !== want.hundredths) begin
                        $display("%0t: distance mismatch: expected %h, got %h",
                                 $time, want.hundredths, o_distance_hundredths);
                        mismatch_count++;
                    end
                    if (o_device_address !== want.addr) begin
                        $display("%0t: address mismatch: expected %h, got %h",
                                 $time, want.addr, o_device_address);
                        mismatch_count++;
                    end
                end
            end
            rx_took = i_rx_valid && !o_rx_stall;
            if (rx_took) begin
                accepted_bytes++;
                parse_rx_byte(i_rx_byte);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_SYNC_ONE:  cfg_sync_one = i_cfg_data;
                    REG_SYNC_TWO:  cfg_sync_two = i_cfg_data;
                    REG_END_BYTE:  cfg_end = i_cfg_data;
                    REG_TYPE_CODE: cfg_type = i_cfg_data;
                    REG_CRC_POLY:  cfg_poly = i_cfg_data;
                    REG_CRC_REFL:  cfg_refl = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // byte driver: holds a request until taken, random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
        end else if (!i_rx_valid || rx_took) begin
            if (frame_bytes.size() > 0 && (no_idle || $urandom_range(99) >= 26)) begin
                i_rx_valid <= 1'b1;
                i_rx_byte <= frame_bytes.pop_front();
            end else begin
                i_rx_valid <= 1'b0;
                i_rx_byte <= 8'($urandom_range(255));
            end
        end
    end

    // result receiver: random stalls plus one long hold-off on request
    int hold_left = 0;
    int hold_seen = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_res_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_res_stall <= 1'b1;
        end else if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = 200;
            i_res_stall <= 1'b1;
        end else begin
            i_res_stall <= !no_idle && ($urandom_range(99) < 26);
        end
    end

    task automatic wait_drained();
        while (accepted_bytes != queued_bytes || expected_ranges.size() != 0)
            @(negedge i_clk);
        // a frame with no result may still be in the parser
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_config(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] e,
                               input logic [7:0] t, input logic [7:0] p, input logic r);
        write_reg(REG_SYNC_ONE, s1);
        write_reg(REG_SYNC_TWO, s2);
        write_reg(REG_END_BYTE, e);
        write_reg(REG_TYPE_CODE, t);
        write_reg(REG_CRC_POLY, p);
        // upper bits of the reflect register are don't-care
        write_reg(REG_CRC_REFL, {7'($urandom_range(127)), r});
        write_reg(REG_SPARE_LO, 8'($urandom_range(255)));
        write_reg(REG_SPARE_HI, 8'($urandom_range(255)));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_frame(input t_frame_kind kind, input logic [7:0] addr,
                               input logic [7:0] err, input logic [15:0] fc,
                               input logic [7:0] type_b, input logic [15:0] dist_val);
        logic [7:0]  body[$];
        logic [7:0]  crc;
        logic [7:0]  b;
        logic [15:0] len;
        int          keep;
        len = 16'(PAYLOAD_LEN);
        if (kind == FR_BAD_LEN) begin
            if ($urandom_range(1)) len = {8'($urandom_range(1, 255)), 8'(PAYLOAD_LEN)};
            else do len = 16'($urandom_range(16'hffff)); while (len == 16'(PAYLOAD_LEN));
        end
        body.push_back(addr);
        body.push_back(err);
        body.push_back(fc[7:0]);
        body.push_back(fc[15:8]);
        body.push_back(len[7:0]);
        body.push_back(len[15:8]);
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            if (i == TYPE_POS) b = type_b;
            else if (i == DIST_POS) b = dist_val[7:0];
            else if (i == DIST_POS + 1) b = dist_val[15:8];
            else b = 8'($urandom_range(255));
            body.push_back(b);
        end
        crc = 8'h00;
        foreach (body[i]) crc = crc8_next(crc, body[i], cfg_poly, cfg_refl);
        if (kind == FR_WILD_CRC) begin
            crc = CRC_WILD;
        end else if (kind == FR_BAD_CRC) begin
            b = crc;
            do crc = 8'($urandom_range(255)); while (crc == b || crc == CRC_WILD);
        end
        body.push_back(crc);
        body.push_back(kind == FR_BAD_END1 ? byte_other_than(cfg_end) : cfg_end);
        body.push_back(kind == FR_BAD_END2 ? byte_other_than(cfg_end) : cfg_end);
        body.push_front(kind == FR_BAD_SYNC2 ? byte_other_than(cfg_sync_two) : cfg_sync_two);
        body.push_front(cfg_sync_one);
        keep = (kind == FR_CUT) ? $urandom_range(1, body.size() - 1) : body.size();
        for (int i = 0; i < keep; i++) frame_bytes.push_back(body[i]);
        queued_bytes += keep;
    endtask

    initial begin : stimulus
        int         phase;
        int         phase_start;
        int         roll;
        logic [7:0] s1;
        logic [15:0] fc;
        logic [7:0] err;
        logic [7:0] tb;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed frames under the reset configuration
        queue_frame(FR_GOOD, 8'hff, 8'h00, FUNC_TARGET, cfg_type, 16'hffff);
        queue_frame(FR_BAD_SYNC2, 8'h12, 8'h00, FUNC_TARGET, cfg_type, 16'h1234);
        queue_frame(FR_BAD_LEN, 8'h34, 8'h00, FUNC_TARGET, cfg_type, 16'h0001);
        queue_frame(FR_WILD_CRC, 8'h00, 8'h00, FUNC_TARGET, cfg_type, 16'h0000);
        queue_frame(FR_BAD_CRC, 8'h56, 8'h00, FUNC_TARGET, cfg_type, 16'h8000);
        queue_frame(FR_BAD_END1, 8'h78, 8'h00, FUNC_TARGET, cfg_type, 16'h00ff);
        queue_frame(FR_BAD_END2, 8'h9a, 8'h00, FUNC_TARGET, cfg_type, 16'hff00);
        queue_frame(FR_CONTENT, 8'hbc, 8'hff, 16'hfc00, ~cfg_type, 16'h5a5a);

        phase = 0;
        while (queued_bytes < 1100) begin
            wait_drained();
            case (phase)
                0: load_config(8'h00, 8'hff, 8'h00, 8'hff, 8'hff, 1'b1);
                1: load_config(8'hff, 8'h00, 8'hff, 8'h00, 8'h00, 1'b0);
                default: begin
                    s1 = 8'($urandom_range(255));
                    load_config(s1, ($urandom_range(3) == 0) ? s1 : 8'($urandom_range(255)),
                                8'($urandom_range(255)), 8'($urandom_range(255)),
                                8'($urandom_range(255)), 1'($urandom_range(1)));
                end
            endcase
            no_idle = (phase == 2);
            if (phase == 3) hold_asked++;
            phase_start = queued_bytes;
            while (queued_bytes - phase_start < 200) begin
                roll = $urandom_range(99);
                fc = ($urandom_range(1)) ? FUNC_TARGET : 16'($urandom_range(16'hffff));
                err = ($urandom_range(1)) ? 8'h00 : 8'($urandom_range(255));
                tb = ($urandom_range(1)) ? cfg_type : 8'($urandom_range(255));
                if (roll < 45)
                    queue_frame(FR_GOOD, 8'($urandom_range(255)), 8'h00, FUNC_TARGET,
                                cfg_type, 16'($urandom_range(16'hffff)));
                else if (roll < 60)
                    queue_frame(FR_CONTENT, 8'($urandom_range(255)), err, fc, tb,
                                16'($urandom_range(16'hffff)));
                else if (roll < 95)
                    queue_frame(roll < 65 ? FR_WILD_CRC : roll < 72 ? FR_BAD_CRC :
                                roll < 78 ? FR_BAD_LEN : roll < 82 ? FR_BAD_SYNC2 :
                                roll < 86 ? FR_BAD_END1 : roll < 90 ? FR_BAD_END2 : FR_CUT,
                                8'($urandom_range(255)), 8'h00, FUNC_TARGET, cfg_type,
                                16'($urandom_range(16'hffff)));
                else begin
                    // line noise between frames
                    repeat ($urandom_range(1, 8)) begin
                        frame_bytes.push_back(8'($urandom_range(255)));
                        queued_bytes++;
                    end
                end
            end
            phase++;
        end

        no_idle = 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #4000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ rangefinder_frame_parser_core.f @@
+incdir+hw/rtl
hw/rtl/rffp_pkg.sv
hw/rtl/rangefinder_frame_parser_core.sv
test/tb_top.sv
